/* rtl/ssbd_pkg.sv */
// ----------------------------------------------------------------------------
// ssbd_pkg: shared types and constants for the SSB demodulator
// Holds the fixed-point widths, request and response payloads, register
// indexes and the quarter-wave oscillator table built at elaboration.
// ----------------------------------------------------------------------------
package ssbd_pkg;

   // Fixed-point widths
   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int STEP_BITS       = 31;
   localparam int ALPHA_BITS      = 15;
   localparam int LP_BITS         = 32;
   localparam int MAG_BITS        = 15;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int QUARTER         = 1 << QUARTER_BITS;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 31;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIDEBAND     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_ALPHA = 2'd2;

   // Request kinds and the operations queued for the back end
   localparam logic KIND_CLEAR = 1'b1;
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   // Sideband select
   localparam logic SIDEBAND_LOWER = 1'b1;

   // Depth of the queue between front and back (a power of two)
   localparam int QUEUE_DEPTH = 2;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] in_phase;
      logic signed [SAMPLE_BITS-1:0] quadrature;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] audio;
   } rsp_payload_type;

   typedef struct packed {
      logic                          op;
      logic signed [SAMPLE_BITS-1:0] in_phase;
      logic signed [SAMPLE_BITS-1:0] quadrature;
   } queue_entry_type;

   typedef struct packed {
      logic [STEP_BITS-1:0]  phase_step;
      logic                  sideband;
      logic [ALPHA_BITS-1:0] filter_alpha;
   } cfg_type;

   typedef logic [MAG_BITS-1:0] quarter_table_type [QUARTER];

   // Sine magnitude for quarter-wave position m, from a Taylor series to
   // the ninth power in Q30, truncating at every step but the last, which rounds.
   function automatic logic [MAG_BITS-1:0] sine_mag(input int unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned mag;
      x   = (64'(m) * HALF_PI_Q30) >> QUARTER_BITS;
      x2  = (x * x) >> 30;
      t   = ONE_Q30 - x2 / 64'd72;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      t   = (x * t) >> 30;
      mag = (t * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return mag[MAG_BITS-1:0];
   endfunction

   function automatic quarter_table_type build_quarter_table();
      quarter_table_type tab;
      for (int k = 0; k < QUARTER; k++) begin
         tab[k] = sine_mag(32'(k));
      end
      return tab;
   endfunction

   localparam quarter_table_type QUARTER_TABLE = build_quarter_table();
   localparam logic [MAG_BITS-1:0] PEAK_MAG = sine_mag(32'(QUARTER));

   // Signed oscillator value for a full-turn table index.
   function automatic logic signed [SAMPLE_BITS-1:0] osc_lookup(
      input logic [SINE_TABLE_BITS-1:0] idx
   );
      logic [1:0]                    quad;
      logic [QUARTER_BITS-1:0]       r;
      logic [QUARTER_BITS:0]         m;
      logic [MAG_BITS-1:0]           mag;
      logic signed [SAMPLE_BITS-1:0] val;
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      r    = idx[QUARTER_BITS-1:0];
      m    = quad[0] ? ((QUARTER_BITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
      mag  = m[QUARTER_BITS] ? PEAK_MAG : QUARTER_TABLE[m[QUARTER_BITS-1:0]];
      val  = signed'({{(SAMPLE_BITS-MAG_BITS){1'b0}}, mag});
      return quad[1] ? -val : val;
   endfunction

endpackage

/* rtl/ssbd_stream_if.sv */
// ----------------------------------------------------------------------------
// ssbd_stream_if: valid/ready stream channel
// Carries one payload per request; a request moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface ssbd_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/ssbd_front.sv */
// ----------------------------------------------------------------------------
// ssbd_front: request intake and queue
// Accepts requests, classifies each as a sample or a clear operation and
// holds them in a short queue for the processing back end.
// ----------------------------------------------------------------------------
module ssbd_front
   import ssbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   ssbd_stream_if.sink     req_if,
   output logic            q_valid,
   input  logic            q_ready,
   output queue_entry_type q_entry
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   queue_entry_type       queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;
   logic                  push;
   logic                  pop;
   queue_entry_type       new_entry;

   // Handshake and read side
   assign req_if.ready = (count_ff != (PTR_BITS+1)'(QUEUE_DEPTH));
   assign q_valid      = (count_ff != '0);
   assign q_entry      = queue_ff[rd_ptr_ff];
   assign push         = req_if.valid && req_if.ready;
   assign pop          = q_valid && q_ready;

   // Classify the incoming request.
   always_comb begin
      new_entry.op         = (req_if.payload.kind == KIND_CLEAR) ? OP_CLEAR : OP_SAMPLE;
      new_entry.in_phase   = req_if.payload.in_phase;
      new_entry.quadrature = req_if.payload.quadrature;
   end

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

/* rtl/ssbd_back.sv */
// ----------------------------------------------------------------------------
// ssbd_back: oscillator, mixer and low-pass sequencer
// One queued operation at a time; a clear zeroes phase and filters, a sample
// gets lookup, complex product, both one-pole filters, a registered output.
// ----------------------------------------------------------------------------
module ssbd_back
   import ssbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            q_valid,
   output logic            q_ready,
   input  queue_entry_type q_entry,
   ssbd_stream_if.source   rsp_if
);

   localparam int PROD_BITS  = 2 * SAMPLE_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int MIX_SHIFT  = 7;
   localparam int MIX_BITS   = SUM_BITS - MIX_SHIFT;
   localparam int DIFF_BITS  = LP_BITS + 1;
   localparam int FPROD_BITS = DIFF_BITS + ALPHA_BITS + 1;
   localparam int F_SHIFT    = 15;
   localparam int OUT_SHIFT  = 8;
   localparam int Y_BITS     = LP_BITS + 1 - OUT_SHIFT;

   localparam logic signed [SUM_BITS-1:0]   MIX_ROUND = SUM_BITS'(1 << (MIX_SHIFT - 1));
   localparam logic signed [FPROD_BITS-1:0] F_ROUND   = FPROD_BITS'(1 << (F_SHIFT - 1));
   localparam logic signed [LP_BITS:0]      OUT_ROUND = (LP_BITS+1)'(1 << (OUT_SHIFT - 1));
   localparam logic signed [Y_BITS-1:0]     Y_MAX     = Y_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Y_BITS-1:0]     Y_MIN     = Y_BITS'(-(1 << (SAMPLE_BITS - 1)));

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MIX  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_FILT = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic signed [LP_BITS-1:0]     lp_re_ff, lp_re_in;
   logic signed [LP_BITS-1:0]     lp_im_ff, lp_im_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_BITS-1:0] si_ff, si_in;
   logic signed [SAMPLE_BITS-1:0] sq_ff, sq_in;
   logic signed [SAMPLE_BITS-1:0] sin_ff, sin_in;
   logic signed [SAMPLE_BITS-1:0] cos_ff, cos_in;
   logic signed [PROD_BITS-1:0]   p_ic_ff, p_ic_in;
   logic signed [PROD_BITS-1:0]   p_qs_ff, p_qs_in;
   logic signed [PROD_BITS-1:0]   p_is_ff, p_is_in;
   logic signed [PROD_BITS-1:0]   p_qc_ff, p_qc_in;
   logic signed [MIX_BITS-1:0]    mix_re_ff, mix_re_in;
   logic signed [MIX_BITS-1:0]    mix_im_ff, mix_im_in;
   logic signed [FPROD_BITS-1:0]  fp_re_ff, fp_re_in;
   logic signed [FPROD_BITS-1:0]  fp_im_ff, fp_im_in;
   logic signed [SAMPLE_BITS-1:0] audio_ff, audio_in;

   logic [SINE_TABLE_BITS-1:0]    sin_idx;
   logic [SINE_TABLE_BITS-1:0]    cos_idx;
   logic [PHASE_BITS-1:0]         step_ext;
   logic [PHASE_BITS-1:0]         phase_adv;
   logic signed [SUM_BITS-1:0]    sum_re;
   logic signed [SUM_BITS-1:0]    sum_im;
   logic signed [DIFF_BITS-1:0]   diff_re;
   logic signed [DIFF_BITS-1:0]   diff_im;
   logic signed [ALPHA_BITS:0]    alpha_s;
   logic signed [FPROD_BITS-1:0]  rnd_re;
   logic signed [FPROD_BITS-1:0]  rnd_im;
   logic signed [LP_BITS:0]       out_sum;
   logic signed [Y_BITS-1:0]      y_val;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic                          out_free;

   // Oscillator index and phase advance
   assign sin_idx   = phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign cos_idx   = sin_idx + SINE_TABLE_BITS'(QUARTER);
   assign step_ext  = PHASE_BITS'(cfg.phase_step);
   assign phase_adv = (cfg.sideband == SIDEBAND_LOWER) ? phase_ff - step_ext
                                                        : phase_ff + step_ext;

   // Mixer sums, rounded to the filter scale by taking the upper bits
   assign sum_re = {p_ic_ff[PROD_BITS-1], p_ic_ff} - {p_qs_ff[PROD_BITS-1], p_qs_ff}
                   + MIX_ROUND;
   assign sum_im = {p_is_ff[PROD_BITS-1], p_is_ff} + {p_qc_ff[PROD_BITS-1], p_qc_ff}
                   + MIX_ROUND;

   // Filter error terms
   assign diff_re = {{(DIFF_BITS-MIX_BITS){mix_re_ff[MIX_BITS-1]}}, mix_re_ff}
                    - {lp_re_ff[LP_BITS-1], lp_re_ff};
   assign diff_im = {{(DIFF_BITS-MIX_BITS){mix_im_ff[MIX_BITS-1]}}, mix_im_ff}
                    - {lp_im_ff[LP_BITS-1], lp_im_ff};
   assign alpha_s = signed'({1'b0, cfg.filter_alpha});
   assign rnd_re  = fp_re_ff + F_ROUND;
   assign rnd_im  = fp_im_ff + F_ROUND;

   // Output rounding and saturation
   assign out_sum = {lp_re_ff[LP_BITS-1], lp_re_ff} + OUT_ROUND;
   assign y_val   = out_sum[LP_BITS:OUT_SHIFT];
   always_comb begin
      if (y_val > Y_MAX) begin
         y_sat = Y_MAX[SAMPLE_BITS-1:0];
      end else if (y_val < Y_MIN) begin
         y_sat = Y_MIN[SAMPLE_BITS-1:0];
      end else begin
         y_sat = y_val[SAMPLE_BITS-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign q_ready  = (state_ff == ST_IDLE);

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      lp_re_in     = lp_re_ff;
      lp_im_in     = lp_im_ff;
      rsp_valid_in = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      si_in        = si_ff;
      sq_in        = sq_ff;
      sin_in       = sin_ff;
      cos_in       = cos_ff;
      p_ic_in      = p_ic_ff;
      p_qs_in      = p_qs_ff;
      p_is_in      = p_is_ff;
      p_qc_in      = p_qc_ff;
      mix_re_in    = mix_re_ff;
      mix_im_in    = mix_im_ff;
      fp_re_in     = fp_re_ff;
      fp_im_in     = fp_im_ff;
      audio_in     = audio_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_entry.op == OP_CLEAR) begin
                  phase_in = '0;
                  lp_re_in = '0;
                  lp_im_in = '0;
               end else begin
                  si_in    = q_entry.in_phase;
                  sq_in    = q_entry.quadrature;
                  sin_in   = osc_lookup(sin_idx);
                  cos_in   = osc_lookup(cos_idx);
                  phase_in = phase_adv;
                  state_in = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            p_ic_in  = si_ff * cos_ff;
            p_qs_in  = sq_ff * sin_ff;
            p_is_in  = si_ff * sin_ff;
            p_qc_in  = sq_ff * cos_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            mix_re_in = sum_re[SUM_BITS-1:MIX_SHIFT];
            mix_im_in = sum_im[SUM_BITS-1:MIX_SHIFT];
            state_in  = ST_FILT;
         end
         ST_FILT: begin
            fp_re_in = alpha_s * diff_re;
            fp_im_in = alpha_s * diff_im;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            lp_re_in = lp_re_ff + rnd_re[F_SHIFT+LP_BITS-1:F_SHIFT];
            lp_im_in = lp_im_ff + rnd_im[F_SHIFT+LP_BITS-1:F_SHIFT];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               audio_in     = y_sat;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         lp_re_ff     <= '0;
         lp_im_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         lp_re_ff     <= lp_re_in;
         lp_im_ff     <= lp_im_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      si_ff     <= si_in;
      sq_ff     <= sq_in;
      sin_ff    <= sin_in;
      cos_ff    <= cos_in;
      p_ic_ff   <= p_ic_in;
      p_qs_ff   <= p_qs_in;
      p_is_ff   <= p_is_in;
      p_qc_ff   <= p_qc_in;
      mix_re_ff <= mix_re_in;
      mix_im_ff <= mix_im_in;
      fp_re_ff  <= fp_re_in;
      fp_im_ff  <= fp_im_in;
      audio_ff  <= audio_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.payload.audio = audio_ff;

endmodule

/* rtl/ssb_bfo_mix_lowpass_demod_unit.sv */
// Responses: a sample request responds once the back end has run its steps;
// a clear request takes effect when the back end takes it from the queue and
// gives no response. The back end takes no new sample until its sequencer has
// run lookup, mix, sum, filter multiply, accumulate and output in turn.
// Reset: synchronous; clears phase, both filter states, the configuration
// registers, the sequencer, the response valid and the request queue pointers.
// ----------------------------------------------------------------------------
// ssb_bfo_mix_lowpass_demod_unit: SSB demodulator top level
// Holds the configuration registers and joins the request front end to the
// oscillator, mixer and low-pass back end.
// ----------------------------------------------------------------------------
module ssb_bfo_mix_lowpass_demod_unit
   import ssbd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   ssbd_stream_if.sink               req_if,
   ssbd_stream_if.source             rsp_if,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            q_valid;
   logic            q_ready;
   queue_entry_type q_entry;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP:   cfg_in.phase_step   = csr_wr_data[STEP_BITS-1:0];
            CSR_SIDEBAND:     cfg_in.sideband     = csr_wr_data[0];
            CSR_FILTER_ALPHA: cfg_in.filter_alpha = csr_wr_data[ALPHA_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request intake and queue
   ssbd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_entry (q_entry)
   );

   // Oscillator, mixer and filter sequencer
   ssbd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_entry (q_entry),
      .rsp_if  (rsp_if)
   );

endmodule
